/* sv/bsf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and bit-search helpers for the bitmap set block.
// No dependencies; every other file imports this package.
package bsf_pkg;

    // Set geometry
    localparam int MAX_ENTRY   = 65535;
    localparam int WORD_BITS   = 64;
    localparam int POS_W       = 6;
    localparam int WORD_COUNT  = 1024;
    localparam int WORD_AW     = 10;
    localparam int ROW_COUNT   = 16;
    localparam int ROW_AW      = 4;
    localparam int IDX_W       = 17;
    localparam int FOUND_W     = 16;
    localparam int ACT_W       = 3;

    localparam logic [IDX_W-1:0] ENTRY_LIMIT = IDX_W'(MAX_ENTRY & 'hffff);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_SET   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UNSET = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TEST  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_EMPTY = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] bit_index;
    } cmd_t;

    typedef struct packed {
        logic               status;
        logic               flag;
        logic [FOUND_W-1:0] found_index;
    } res_t;

    // Port request to the word store
    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [WORD_AW-1:0]   addr;
        logic [WORD_BITS-1:0] wdata;
    } word_req_t;

    // Port request to the summary store (one bit per word)
    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [ROW_AW-1:0]    addr;
        logic [WORD_BITS-1:0] wdata;
    } row_req_t;

    // Position of the lowest set bit of a 64-bit word (0 when empty)
    function automatic logic [POS_W-1:0] lowest_set64(input logic [WORD_BITS-1:0] v);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

    // Position of the lowest set bit of the top-level summary (0 when empty)
    function automatic logic [ROW_AW-1:0] lowest_set16(input logic [ROW_COUNT-1:0] v);
        logic [ROW_AW-1:0] pos;
        pos = '0;
        for (int i = ROW_COUNT - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = ROW_AW'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* sv/bsf_ram.sv */
`timescale 1ns / 1ps
// Single-port synchronous RAM with registered read data.
// Depends on bsf_pkg for default sizes.
module bsf_ram
    import bsf_pkg::*;
#(
    parameter int DEPTH  = WORD_COUNT,
    parameter int DATA_W = WORD_BITS,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write, or read into the registered output
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* sv/bsf_ctrl.sv */
`timescale 1ns / 1ps
// Request sequencer: read-modify-write of the word and summary stores,
// three-level find-next search, and the top summary register. Uses bsf_pkg.
module bsf_ctrl
    import bsf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res,
    output word_req_t            word_req,
    input  logic [WORD_BITS-1:0] word_rdata,
    output row_req_t             row_req,
    input  logic [WORD_BITS-1:0] row_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_ROW  = 3'd2;
    localparam logic [2:0] S_WORD = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [ACT_W-1:0]     action_reg, action_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [WORD_AW-1:0]   wsel_reg, wsel_next;
    logic [ROW_COUNT-1:0] l2_reg, l2_next;
    res_t                 res_reg, res_next;

    // Fields of the held request
    logic [WORD_AW-1:0]   w0;
    logic [ROW_AW-1:0]    r0;
    logic [POS_W-1:0]     wpos;
    logic [POS_W-1:0]     bpos;
    logic                 in_range;

    // Effective contents: an entry whose summary bit is clear reads as zero
    logic [WORD_BITS-1:0] eff_row;
    logic [WORD_BITS-1:0] eff_word;
    logic [WORD_BITS-1:0] bitmask;
    logic [WORD_BITS-1:0] rowbit;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] new_row;
    logic [WORD_BITS-1:0] hits;
    logic [WORD_BITS-1:0] row_hits;
    logic [ROW_COUNT-1:0] l2_hits;

    assign w0       = idx_reg[FOUND_W-1:POS_W];
    assign r0       = w0[WORD_AW-1:POS_W];
    assign wpos     = w0[POS_W-1:0];
    assign bpos     = idx_reg[POS_W-1:0];
    assign in_range = (idx_reg <= ENTRY_LIMIT);

    assign eff_row  = l2_reg[r0] ? row_rdata : '0;
    assign eff_word = eff_row[wpos] ? word_rdata : '0;
    assign bitmask  = WORD_BITS'(1) << bpos;
    assign rowbit   = WORD_BITS'(1) << wpos;

    // Updated word and summary row for set and unset
    always_comb
    begin
        if (action_reg == ACT_SET)
        begin
            new_word = eff_word | bitmask;
        end
        else
        begin
            new_word = eff_word & ~bitmask;
        end
        new_row = (new_word != '0) ? (eff_row | rowbit) : (eff_row & ~rowbit);
    end

    // Search masks: bits at or above the start, then words and rows above it
    assign hits     = eff_word & ({WORD_BITS{1'b1}} << bpos);
    assign row_hits = eff_row & ({WORD_BITS{1'b1}} << wpos) & ~rowbit;
    assign l2_hits  = l2_reg & ({ROW_COUNT{1'b1}} << r0) & ~(ROW_COUNT'(1) << r0);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_HOLD);
    assign res       = res_reg;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        idx_next    = idx_reg;
        wsel_next   = wsel_reg;
        l2_next     = l2_reg;
        res_next    = res_reg;
        word_req    = '0;
        row_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    action_next    = cmd.action;
                    idx_next       = cmd.bit_index;
                    word_req.rd_en = 1'b1;
                    word_req.addr  = cmd.bit_index[FOUND_W-1:POS_W];
                    row_req.rd_en  = 1'b1;
                    row_req.addr   = cmd.bit_index[FOUND_W-1:FOUND_W-ROW_AW];
                    state_next     = S_EVAL;
                end
            end

            S_EVAL:
            begin
                res_next   = '0;
                state_next = S_HOLD;
                unique case (action_reg)
                    ACT_SET, ACT_UNSET:
                    begin
                        if (in_range)
                        begin
                            word_req.wr_en = 1'b1;
                            word_req.addr  = w0;
                            word_req.wdata = new_word;
                            row_req.wr_en  = 1'b1;
                            row_req.addr   = r0;
                            row_req.wdata  = new_row;
                            l2_next[r0]    = (new_row != '0);
                        end
                        else if (action_reg == ACT_SET)
                        begin
                            res_next.status = 1'b1;
                        end
                    end
                    ACT_TEST:
                    begin
                        res_next.flag = in_range & eff_word[bpos];
                    end
                    ACT_FIND:
                    begin
                        if (in_range)
                        begin
                            priority if (hits != '0)
                            begin
                                res_next.flag        = 1'b1;
                                res_next.found_index = {w0, lowest_set64(hits)};
                            end
                            else if (row_hits != '0)
                            begin
                                wsel_next      = {r0, lowest_set64(row_hits)};
                                word_req.rd_en = 1'b1;
                                word_req.addr  = {r0, lowest_set64(row_hits)};
                                state_next     = S_WORD;
                            end
                            else if (l2_hits != '0)
                            begin
                                wsel_next     = {lowest_set16(l2_hits), POS_W'(0)};
                                row_req.rd_en = 1'b1;
                                row_req.addr  = lowest_set16(l2_hits);
                                state_next    = S_ROW;
                            end
                            else
                            begin
                                // Nothing set at or above the start
                                res_next.flag = 1'b0;
                            end
                        end
                    end
                    ACT_EMPTY:
                    begin
                        res_next.flag = (l2_reg == '0);
                    end
                    ACT_CLEAR:
                    begin
                        l2_next = '0;
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end

            // First non-empty word of a non-empty row
            S_ROW:
            begin
                wsel_next      = {wsel_reg[WORD_AW-1:POS_W], lowest_set64(row_rdata)};
                word_req.rd_en = 1'b1;
                word_req.addr  = {wsel_reg[WORD_AW-1:POS_W], lowest_set64(row_rdata)};
                state_next     = S_WORD;
            end

            // Lowest bit of a word known to be non-empty
            S_WORD:
            begin
                res_next.status      = 1'b0;
                res_next.flag        = 1'b1;
                res_next.found_index = {wsel_reg, lowest_set64(word_rdata)};
                state_next           = S_HOLD;
            end

            S_HOLD:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            l2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            l2_reg    <= l2_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        idx_reg    <= idx_next;
        wsel_reg   <= wsel_next;
        res_reg    <= res_next;
    end

    // A new request always moves straight to evaluation
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg == S_EVAL))
        else $error("accepted item did not enter evaluation");

    // The single-port word store never sees a read and a write together
    a_word_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(word_req.rd_en && word_req.wr_en))
        else $error("word store read and write in the same cycle");

    // A word reached through the summary holds at least one set bit
    a_word_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WORD) |-> (word_rdata != '0))
        else $error("summary points at an empty word");

    // A row reached through the top summary holds at least one set bit
    a_row_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> (row_rdata != '0))
        else $error("top summary points at an empty row");

    // Clear-all leaves the top summary empty
    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && action_reg == ACT_CLEAR) |=> (l2_reg == '0))
        else $error("clear-all left summary bits set");

endmodule

/* sv/bitmap_set_with_find_next.sv */
`timescale 1ns / 1ps
// Bitmap set of integers 0..65535 with find-next-set-bit, top level.
// Instantiates bsf_ctrl and two bsf_ram stores; uses bsf_pkg.
//
// Usage:
//   Requests enter on s_axis: tuser carries the action, tdata the bit index.
//   Each request gives exactly one result item on m_axis: tdata carries the
//   found index, tuser the status and flag bits.
//   Bits live in a 1024 x 64 word store; a 16 x 64 summary store holds one
//   non-empty bit per word and a 16-bit register one bit per summary row.
//   An entry whose summary bit is clear reads as zero, so no store needs
//   a clearing pass: reset and clear-all only clear the 16-bit register.
//   After acceptance a request reads the stores and is evaluated; a
//   find-next that moves on to a later row reads the summary store and then
//   the word store, one that moves to a later word only the word store.
//   One request is in work at a time, so a new item is taken only after the
//   last result has moved on. The result sits in an output register; the next
//   request is accepted and worked on while it waits, and holds in its last
//   step until the output register frees up. s_axis_tready is high whenever
//   no request is in progress, reset included; reset empties the set at once.
module bitmap_set_with_find_next
    import bsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [16:0] bit_index, [23:17] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] found_index
    output logic [1:0]  m_axis_tuser    // [0] status, [1] flag
);

    cmd_t                 cmd;
    res_t                 res;
    logic                 res_valid;
    logic                 res_ready;
    word_req_t            word_req;
    row_req_t             row_req;
    logic [WORD_BITS-1:0] word_rdata;
    logic [WORD_BITS-1:0] row_rdata;

    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg, out_res_next;

    assign cmd.action    = s_axis_tuser;
    assign cmd.bit_index = s_axis_tdata[IDX_W-1:0];

    bsf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (s_axis_tvalid),
        .cmd_ready  (s_axis_tready),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .word_req   (word_req),
        .word_rdata (word_rdata),
        .row_req    (row_req),
        .row_rdata  (row_rdata)
    );

    // Word store: one bit per set member
    bsf_ram #(
        .DEPTH  (WORD_COUNT),
        .DATA_W (WORD_BITS)
    ) u_word_ram (
        .clk   (clk),
        .en    (word_req.rd_en | word_req.wr_en),
        .we    (word_req.wr_en),
        .addr  (word_req.addr),
        .wdata (word_req.wdata),
        .rdata (word_rdata)
    );

    // Summary store: one non-empty bit per word
    bsf_ram #(
        .DEPTH  (ROW_COUNT),
        .DATA_W (WORD_BITS)
    ) u_row_ram (
        .clk   (clk),
        .en    (row_req.rd_en | row_req.wr_en),
        .we    (row_req.wr_en),
        .addr  (row_req.addr),
        .wdata (row_req.wdata),
        .rdata (row_rdata)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        priority if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            // Held item stays until the receiver takes it
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.found_index;
    assign m_axis_tuser  = {out_res_reg.flag, out_res_reg.status};

endmodule
